// File: rtl/core/hsv_to_rgb_pixel_defines.svh
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel assertion macros
// clocked property checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PIXEL_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_DEFINES_SVH

`ifndef SYNTH
`define H2R_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hsv_to_rgb_pixel assertion failed");
`define H2R_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("hsv_to_rgb_pixel assertion failed");
`else
`define H2R_ASSERT(name, clk, rst_n, prop)
`define H2R_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// File: rtl/core/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg
// types, constants and helpers of the hsv to rgb pixel converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package h2r_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned HueW   = 9;
  localparam int unsigned ProdW  = 16;
  localparam int unsigned PosW   = 6;
  localparam int unsigned NumW   = 24;
  localparam int unsigned RecipW = 18;
  localparam int unsigned QuotW  = 9;
  localparam int unsigned RecipShift = 32;

  // rounding divide by 2 * 15300 done as multiply by floor(2^32 / 30600)
  localparam logic [14:0]       DivC   = 15'd30600;
  localparam logic [RecipW-1:0] RecipC = 18'd140358;
  localparam logic [NumW-1:0]   BiasC  = 24'd15300;
  localparam logic [7:0]        LowMulC = 8'd120;

  localparam logic [HueW-1:0] Hue60  = 9'd60;
  localparam logic [HueW-1:0] Hue120 = 9'd120;
  localparam logic [HueW-1:0] Hue180 = 9'd180;
  localparam logic [HueW-1:0] Hue240 = 9'd240;
  localparam logic [HueW-1:0] Hue300 = 9'd300;
  localparam logic [HueW-1:0] Hue360 = 9'd360;
  localparam logic [HueW-1:0] Hue480 = 9'd480;

  typedef enum logic [2:0] {
    SEC_RED_GRN  = 3'd0,
    SEC_GRN_RED  = 3'd1,
    SEC_GRN_BLU  = 3'd2,
    SEC_BLU_GRN  = 3'd3,
    SEC_BLU_RED  = 3'd4,
    SEC_RED_BLU  = 3'd5
  } h2r_sector_e;

  // estimate is exact or one low; fix it and saturate
  function automatic logic [ChanW-1:0] h2r_fix(input logic [NumW-1:0] num,
                                               input logic [QuotW-1:0] est);
    logic [NumW-1:0] prod;
    logic [NumW-1:0] rem;
    logic [QuotW:0]  quo;
    prod = NumW'(est) * NumW'(DivC);
    rem  = num - prod;
    quo  = {1'b0, est} + ((rem >= NumW'(DivC)) ? (QuotW+1)'(1) : (QuotW+1)'(0));
    return (quo > (QuotW+1)'(255)) ? 8'hff : quo[ChanW-1:0];
  endfunction

endpackage

// File: rtl/core/hsv_to_rgb_pixel.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel
// converts hue, saturation, value and alpha into rounded rgb bytes and alpha
// ----------------------------------------------------------------------------
//
//  channel | signals                                      | dir
//  --------+----------------------------------------------+-----
//  pixel   | valid_i, stall_o, hue_i, saturation_i,       | in
//          | brightness_i, alpha_in_i                     |
//  color   | valid_o, stall_i, red_o, green_o, blue_o,    | out
//          | alpha_out_o                                  |
//
//  one item per cycle unless stall_i holds the output; four register stages in
//  order: product, numerators, reciprocal, fix and select
//  each stage holds while the one after it is full and held; empty stages fill
//  reset clears the valid bits only, no item is lost or repeated on a stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hsv_to_rgb_pixel_defines.svh"

module hsv_to_rgb_pixel (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [h2r_pkg::HueW-1:0]   hue_i,
  input  logic [h2r_pkg::ChanW-1:0]  saturation_i,
  input  logic [h2r_pkg::ChanW-1:0]  brightness_i,
  input  logic [h2r_pkg::ChanW-1:0]  alpha_in_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [h2r_pkg::ChanW-1:0]  red_o,
  output logic [h2r_pkg::ChanW-1:0]  green_o,
  output logic [h2r_pkg::ChanW-1:0]  blue_o,
  output logic [h2r_pkg::ChanW-1:0]  alpha_out_o
);
  import h2r_pkg::*;

  logic en1, en2, en3, en4;
  logic vld1_q, vld2_q, vld3_q, vld4_q;

  // stage 1
  logic [ChanW-1:0] v1_q, a1_q;
  logic [ProdW-1:0] vs1_q;
  logic [PosW-1:0]  pos1_q;
  h2r_sector_e      sec1_q;
  logic [HueW-1:0]  hmod;
  logic [HueW-1:0]  pos_full;
  h2r_sector_e      sec_d;

  // stage 2
  logic [ChanW-1:0] v2_q, a2_q;
  h2r_sector_e      sec2_q;
  logic [NumW-1:0]  nlow2_q, nramp2_q;
  logic [ProdW-1:0] x2;
  logic [NumW-1:0]  nlow_d;
  logic [NumW-1:0]  nramp_d;

  // stage 3
  logic [ChanW-1:0] v3_q, a3_q;
  h2r_sector_e      sec3_q;
  logic [NumW-1:0]  nlow3_q, nramp3_q;
  logic [QuotW-1:0] qlow3_q, qramp3_q;
  logic [NumW+RecipW-1:0] plow, pramp;

  // stage 4
  logic [ChanW-1:0] low4, ramp4;
  logic [ChanW-1:0] red_q, green_q, blue_q, alpha_q;
  logic [ChanW-1:0] red_d, green_d, blue_d;

  assign en4     = !vld4_q || !stall_i;
  assign en3     = !vld3_q || en4;
  assign en2     = !vld2_q || en3;
  assign en1     = !vld1_q || en2;
  assign stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      if (en1) vld1_q <= valid_i;
      if (en2) vld2_q <= vld1_q;
      if (en3) vld3_q <= vld2_q;
      if (en4) vld4_q <= vld3_q;
    end
  end

  // hue mod 120 and sector
  always_comb begin
    if (hue_i < Hue120)      hmod = hue_i;
    else if (hue_i < Hue240) hmod = hue_i - Hue120;
    else if (hue_i < Hue360) hmod = hue_i - Hue240;
    else if (hue_i < Hue480) hmod = hue_i - Hue360;
    else                     hmod = hue_i - Hue480;
    pos_full = (hmod <= Hue60) ? hmod : (Hue120 - hmod);
    if (hue_i < Hue60)       sec_d = SEC_RED_GRN;
    else if (hue_i < Hue120) sec_d = SEC_GRN_RED;
    else if (hue_i < Hue180) sec_d = SEC_GRN_BLU;
    else if (hue_i < Hue240) sec_d = SEC_BLU_GRN;
    else if (hue_i < Hue300) sec_d = SEC_BLU_RED;
    else                     sec_d = SEC_RED_BLU;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      v1_q   <= brightness_i;
      a1_q   <= alpha_in_i;
      vs1_q  <= ProdW'(brightness_i) * ProdW'(saturation_i);
      pos1_q <= pos_full[PosW-1:0];
      sec1_q <= sec_d;
    end
  end

  // numerators over the common denominator, doubled for rounding
  assign x2      = (ProdW'(v1_q) << 8) - ProdW'(v1_q) - vs1_q;
  assign nlow_d  = NumW'(x2) * NumW'(LowMulC) + BiasC;
  assign nramp_d = nlow_d + ((NumW'(vs1_q) * NumW'(pos1_q)) << 1);

  always_ff @(posedge clk_i) begin
    if (en2 && vld1_q) begin
      v2_q     <= v1_q;
      a2_q     <= a1_q;
      sec2_q   <= sec1_q;
      nlow2_q  <= nlow_d;
      nramp2_q <= nramp_d;
    end
  end

  assign plow  = (NumW+RecipW)'(nlow2_q) * (NumW+RecipW)'(RecipC);
  assign pramp = (NumW+RecipW)'(nramp2_q) * (NumW+RecipW)'(RecipC);

  always_ff @(posedge clk_i) begin
    if (en3 && vld2_q) begin
      v3_q     <= v2_q;
      a3_q     <= a2_q;
      sec3_q   <= sec2_q;
      nlow3_q  <= nlow2_q;
      nramp3_q <= nramp2_q;
      qlow3_q  <= plow[RecipShift +: QuotW];
      qramp3_q <= pramp[RecipShift +: QuotW];
    end
  end

  assign low4  = h2r_fix(nlow3_q, qlow3_q);
  assign ramp4 = h2r_fix(nramp3_q, qramp3_q);

  always_comb begin
    case (sec3_q)
      SEC_RED_GRN: begin red_d = v3_q;  green_d = ramp4; blue_d = low4;  end
      SEC_GRN_RED: begin red_d = ramp4; green_d = v3_q;  blue_d = low4;  end
      SEC_GRN_BLU: begin red_d = low4;  green_d = v3_q;  blue_d = ramp4; end
      SEC_BLU_GRN: begin red_d = low4;  green_d = ramp4; blue_d = v3_q;  end
      SEC_BLU_RED: begin red_d = ramp4; green_d = low4;  blue_d = v3_q;  end
      default:     begin red_d = v3_q;  green_d = low4;  blue_d = ramp4; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4 && vld3_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= a3_q;
    end
  end

  assign valid_o     = vld4_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_out_o = alpha_q;

  `H2R_ASSERT_ALWAYS(a_stall_only_when_full, clk_i, stall_o |-> (valid_o && stall_i))
  `H2R_ASSERT(a_low_not_above_ramp, clk_i, rst_ni, vld3_q |-> (low4 <= ramp4))
  `H2R_ASSERT(a_ramp_not_above_full, clk_i, rst_ni, vld3_q |-> (ramp4 <= v3_q))
  `H2R_ASSERT(a_out_from_stage3, clk_i, rst_ni, $rose(valid_o) |-> $past(vld3_q))

endmodule

// File: verif/hsv_to_rgb_pixel_tb.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_tb
// self-checking bench for the hsv to rgb pixel converter: a table of directed
// pixels, then random pixels over the full 9-bit hue and byte ranges, with
// random idling on both channels and a cycle-free integer color predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_tb;

  import h2r_pkg::*;

  localparam int unsigned Denom     = 15300;
  localparam int unsigned SectorDeg = 60;
  localparam int unsigned RampSpan  = 120;
  localparam int unsigned MaxChan   = 255;
  localparam int unsigned NumRandom = 450;
  localparam int unsigned QuietTail = 60;
  localparam int unsigned DrainWait = 8;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } color_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
    logic [ChanW-1:0] alpha;
    logic             typed;
    color_t           color;
  } pixel_row_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             valid_i      = 1'b0;
  logic             stall_o;
  logic [HueW-1:0]  hue_i        = '0;
  logic [ChanW-1:0] saturation_i = '0;
  logic [ChanW-1:0] brightness_i = '0;
  logic [ChanW-1:0] alpha_in_i   = '0;
  logic             valid_o;
  logic             stall_i      = 1'b0;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;
  logic [ChanW-1:0] alpha_out_o;

  // side data that travels with the driven item
  logic   row_typed = 1'b0;
  color_t row_color = '0;

  bit     quiet = 1'b0;
  color_t pending_colors [$];
  color_t want;
  int     pixels_sent    = 0;
  int     colors_checked = 0;
  int     typed_rows     = 0;
  int     wide_hues      = 0;
  int     mismatches     = 0;
  int     stall_left     = 0;

  pixel_row_t directed_rows [22] = '{
    '{9'd0,   8'd255, 8'd255, 8'd0,   1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
    '{9'd60,  8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0,   8'd255}},
    '{9'd120, 8'd255, 8'd255, 8'd17,  1'b1, '{8'd0,   8'd255, 8'd0,   8'd17}},
    '{9'd180, 8'd255, 8'd255, 8'd34,  1'b1, '{8'd0,   8'd255, 8'd255, 8'd34}},
    '{9'd240, 8'd255, 8'd255, 8'd51,  1'b1, '{8'd0,   8'd0,   8'd255, 8'd51}},
    '{9'd300, 8'd255, 8'd255, 8'd68,  1'b1, '{8'd255, 8'd0,   8'd255, 8'd68}},
    '{9'd77,  8'd0,   8'd200, 8'd85,  1'b1, '{8'd200, 8'd200, 8'd200, 8'd85}},
    '{9'd359, 8'd255, 8'd0,   8'd102, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd102}},
    '{9'd360, 8'd255, 8'd255, 8'd136, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd136}},
    '{9'd0,   8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   8'd0}},
    '{9'd511, 8'd255, 8'd255, 8'd119, 1'b0, '0},
    '{9'd420, 8'd200, 8'd180, 8'd153, 1'b0, '0},
    '{9'd480, 8'd128, 8'd128, 8'd170, 1'b0, '0},
    '{9'd59,  8'd255, 8'd255, 8'd187, 1'b0, '0},
    '{9'd61,  8'd1,   8'd1,   8'd204, 1'b0, '0},
    '{9'd119, 8'd255, 8'd1,   8'd221, 1'b0, '0},
    '{9'd239, 8'd1,   8'd255, 8'd238, 1'b0, '0},
    '{9'd241, 8'd128, 8'd255, 8'd1,   1'b0, '0},
    '{9'd359, 8'd255, 8'd255, 8'd254, 1'b0, '0},
    '{9'd1,   8'd128, 8'd64,  8'd128, 1'b0, '0},
    '{9'd299, 8'd200, 8'd100, 8'd90,  1'b0, '0},
    '{9'd256, 8'd170, 8'd85,  8'd255, 1'b0, '0}
  };

  hsv_to_rgb_pixel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .alpha_in_i   (alpha_in_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_out_o  (alpha_out_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [ChanW-1:0] round_chan(input int unsigned num);
    int unsigned quo;
    quo = (2 * num + Denom) / (2 * Denom);
    return (quo > MaxChan) ? ChanW'(MaxChan) : ChanW'(quo);
  endfunction

  function automatic color_t hsv_to_color(input logic [HueW-1:0] h, input logic [ChanW-1:0] s,
                                          input logic [ChanW-1:0] v, input logic [ChanW-1:0] a);
    int unsigned  prod;
    int unsigned  pos;
    int unsigned  floor_num;
    logic [7:0]   top;
    logic [7:0]   low;
    logic [7:0]   ramp;
    h2r_sector_e  sector;
    color_t       c;
    prod      = int'(v) * int'(s);
    pos       = int'(h) % RampSpan;
    if (pos > SectorDeg) pos = RampSpan - pos;
    floor_num = int'(v) * Denom - prod * SectorDeg;
    top       = v;
    low       = round_chan(floor_num);
    ramp      = round_chan(floor_num + prod * pos);
    // hues past 359 stay in the last sector
    sector    = (int'(h) / SectorDeg > 5) ? SEC_RED_BLU : h2r_sector_e'(int'(h) / SectorDeg);
    case (sector)
      SEC_RED_GRN: c = '{top,  ramp, low,  a};
      SEC_GRN_RED: c = '{ramp, top,  low,  a};
      SEC_GRN_BLU: c = '{low,  top,  ramp, a};
      SEC_BLU_GRN: c = '{low,  ramp, top,  a};
      SEC_BLU_RED: c = '{ramp, low,  top,  a};
      default:     c = '{top,  low,  ramp, a};
    endcase
    return c;
  endfunction

  task automatic check_field(input string name, input logic [ChanW-1:0] exp_v,
                             input logic [ChanW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // accepted pixels become expected colors, accepted colors are checked in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        if (row_typed) pending_colors.push_back(row_color);
        else pending_colors.push_back(hsv_to_color(hue_i, saturation_i, brightness_i,
                                                   alpha_in_i));
      end
      if (valid_o && !stall_i) begin
        if (pending_colors.size() == 0) begin
          $error("color item with no pixel waiting: r %0d g %0d b %0d a %0d",
                 red_o, green_o, blue_o, alpha_out_o);
          mismatches++;
        end else begin
          want = pending_colors.pop_front();
          check_field("red", want.red, red_o);
          check_field("green", want.green, green_o);
          check_field("blue", want.blue, blue_o);
          check_field("alpha_out", want.alpha, alpha_out_o);
          colors_checked++;
        end
      end
    end
  end

  // output stall in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && rst_ni && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    stall_i <= (stall_left > 0);
  end

  task automatic send_pixel(input logic [HueW-1:0] h, input logic [ChanW-1:0] s,
                            input logic [ChanW-1:0] v, input logic [ChanW-1:0] a,
                            input logic typed, input color_t c);
    hue_i        <= h;
    saturation_i <= s;
    brightness_i <= v;
    alpha_in_i   <= a;
    row_typed    <= typed;
    row_color    <= c;
    valid_i      <= 1'b1;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    pixels_sent++;
    if (h > 9'd359) wide_hues++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_colors();
    valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_colors.size() == 0);
    @(posedge clk_i);
  endtask

  function automatic logic [ChanW-1:0] rand_byte();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [HueW-1:0] rand_hue();
    case ($urandom_range(0, 7))
      0:       return HueW'($urandom_range(360, 511));
      1:       return HueW'($urandom_range(0, 6) * SectorDeg + $urandom_range(0, 2)
                             - ($urandom_range(0, 1) ? 0 : 1) + 1) % 9'd360;
      default: return HueW'($urandom_range(0, 359));
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) typed_rows++;
      send_pixel(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].val,
                 directed_rows[i].alpha, directed_rows[i].typed, directed_rows[i].color);
    end
    drain_colors();
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) drain_colors();
      if (n == NumRandom - QuietTail) quiet = 1'b1;
      send_pixel(rand_hue(), rand_byte(), rand_byte(), ChanW'($urandom_range(0, 255)),
                 1'b0, '0);
    end
    drain_colors();
    repeat (DrainWait) @(posedge clk_i);
    $display("covered %0d pixels (%0d hand-checked, %0d with hue above 359), %0d colors",
             pixels_sent, typed_rows, wide_hues, colors_checked);
    $display("primary and secondary hues, grey and black, wide hues, idling on both sides");
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
